// File: sv/utf8s_pkg.sv
// Shared types and lead-byte decode for the UTF-8 character splitter.
`timescale 1ns / 1ps

package utf8s_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CharW    = ByteW * MaxBytes;       // 48
  localparam int unsigned PartW    = ByteW * (MaxBytes - 1); // 40
  localparam int unsigned LenW     = 3;

  localparam logic [LenW-1:0] LenInvalid = 3'd0;
  localparam logic [LenW-1:0] LenOne     = 3'd1;
  localparam logic [LenW-1:0] LastPos    = 3'd5;

  typedef struct packed {
    logic [CharW-1:0] char_bits;
    logic [LenW-1:0]  char_length;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } seg_res_t;

  // Length announced by a lead byte; LenInvalid if it cannot start a character.
  function automatic logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    priority if ((b & 8'h80) == 8'h00) n = 3'd1;
    else if ((b & 8'hE0) == 8'hC0)     n = 3'd2;
    else if ((b & 8'hF0) == 8'hE0)     n = 3'd3;
    else if ((b & 8'hF8) == 8'hF0)     n = 3'd4;
    else if ((b & 8'hFC) == 8'hF8)     n = 3'd5;
    else if ((b & 8'hFE) == 8'hFC)     n = 3'd6;
    else                               n = LenInvalid;
    return n;
  endfunction

endpackage

// File: sv/utf8s_if.sv
// Valid/ready channel interfaces for the byte input and the character output.
`timescale 1ns / 1ps

interface utf8s_in_if;
  import utf8s_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utf8s_out_if;
  import utf8s_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_bits;
  logic [LenW-1:0]  char_length;

  modport source (output valid, output char_bits, output char_length, input ready);
  modport sink   (input valid, input char_bits, input char_length, output ready);
endinterface

// File: sv/utf8s_seg.sv
// Character collection state and per-byte classify/append logic.
`timescale 1ns / 1ps

module utf8s_seg
  import utf8s_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             eos_i,
  output seg_res_t         res_o
);

  logic [PartW-1:0] partial_q, partial_d;
  logic [LenW-1:0]  exp_q, exp_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic             halt_q, halt_d;

  logic [LenW-1:0]  lead_n;
  logic [LenW-1:0]  pos;
  logic [CharW-1:0] word;
  logic             is_cont;
  logic             done;

  assign lead_n  = lead_length(byte_i);
  assign is_cont = (byte_i[7:6] == 2'b10);
  assign pos     = (cnt_q > LastPos) ? LastPos : cnt_q;
  assign word    = {{(CharW-PartW){1'b0}}, partial_q}
                 | ({{(CharW-ByteW){1'b0}}, byte_i} << (ByteW * pos));
  assign done    = ({1'b0, cnt_q} + 4'd1) >= {1'b0, exp_q};

  always_comb begin
    partial_d  = partial_q;
    exp_d      = exp_q;
    cnt_d      = cnt_q;
    halt_d     = halt_q;
    res_o      = '0;
    if (!halt_q) begin
      if (cnt_q == '0) begin
        if (lead_n == LenInvalid) begin
          halt_d    = 1'b1;
          partial_d = '0;
          exp_d     = '0;
          cnt_d     = '0;
        end else if (lead_n == LenOne) begin
          res_o.valid            = 1'b1;
          res_o.data.char_bits   = {{(CharW-ByteW){1'b0}}, byte_i};
          res_o.data.char_length = LenOne;
        end else begin
          partial_d = {{(PartW-ByteW){1'b0}}, byte_i};
          exp_d     = lead_n;
          cnt_d     = 3'd1;
        end
      end else if (!is_cont) begin
        // broken sequence: drop the partial character
        halt_d    = 1'b1;
        partial_d = '0;
        exp_d     = '0;
        cnt_d     = '0;
      end else if (done) begin
        res_o.valid            = 1'b1;
        res_o.data.char_bits   = word;
        res_o.data.char_length = exp_q;
        partial_d = '0;
        exp_d     = '0;
        cnt_d     = '0;
      end else begin
        partial_d = word[PartW-1:0];
        cnt_d     = cnt_q + 3'd1;
      end
    end
    if (eos_i) begin
      partial_d = '0;
      exp_d     = '0;
      cnt_d     = '0;
      halt_d    = 1'b0;
    end
    res_o.valid = res_o.valid & fire_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      exp_q     <= '0;
      cnt_q     <= '0;
      halt_q    <= 1'b0;
    end else if (fire_i) begin
      partial_q <= partial_d;
      exp_q     <= exp_d;
      cnt_q     <= cnt_d;
      halt_q    <= halt_d;
    end
  end

endmodule

// File: sv/utf8s_skid.sv
// Result register with a skid entry so input keeps flowing during output stalls.
`timescale 1ns / 1ps

module utf8s_skid
  import utf8s_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  seg_res_t push_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output res_t     out_data_o,
  output logic     full_o
);

  logic out_valid_q;
  res_t out_q;
  logic skid_valid_q;
  res_t skid_q;
  logic advance;

  // push_i only arrives while the skid entry is empty
  assign advance = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (advance) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= push_i.valid;
      end
    end else if (push_i.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= skid_valid_q ? skid_q : push_i.data;
    end else if (push_i.valid) begin
      skid_q <= push_i.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full_o      = skid_valid_q;

endmodule

// File: sv/utf8_character_splitter.sv
// Top level: UTF-8 character splitter, one byte per item, one character per result.
// A completed character is registered on the output, or in the skid entry on a stall.
// Throughput: 1 byte per cycle; the per-byte classify/append is a single registered pass.
// Input stalls only while a result is held on the output and a second one waits in the skid.
// Reset (async, active low) clears the collection state, halt flag and output valid.
`timescale 1ns / 1ps

module utf8_character_splitter
  import utf8s_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  utf8s_in_if.sink    in_i,
  utf8s_out_if.source out_o
);

  logic     fire;
  logic     full;
  logic     out_valid;
  res_t     out_data;
  seg_res_t seg_res;

  assign in_i.ready = !full;
  assign fire       = in_i.valid && !full;

  utf8s_seg u_seg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_i.in_byte),
    .eos_i  (in_i.end_of_string),
    .res_o  (seg_res)
  );

  utf8s_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (seg_res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .full_o      (full)
  );

  assign out_o.valid       = out_valid;
  assign out_o.char_bits   = out_data.char_bits;
  assign out_o.char_length = out_data.char_length;

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_length != 3'd0 && out_o.char_length != 3'd7))
    else $error("char_length out of range");

  a_one_byte_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.char_length == 3'd1) |-> (out_o.char_bits[CharW-1:ByteW] == '0))
    else $error("single-byte character has nonzero upper bytes");

  a_two_byte_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.char_length == 3'd2) |-> (out_o.char_bits[CharW-1:2*ByteW] == '0))
    else $error("two-byte character has nonzero upper bytes");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no result pending");

endmodule
